>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Types, constants and character classes shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Width of the position and line counters inside the block.
  localparam int POS_W = 16;
  // Width of the offset, length and line fields of a token.
  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Depth of the result queue and its index widths.
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  // Token kinds.
  localparam logic [3:0] KIND_INT   = 4'd0;
  localparam logic [3:0] KIND_FLOAT = 4'd1;
  localparam logic [3:0] KIND_ID    = 4'd2;
  localparam logic [3:0] KIND_SEMI  = 4'd3;
  localparam logic [3:0] KIND_LPAR  = 4'd4;
  localparam logic [3:0] KIND_RPAR  = 4'd5;
  localparam logic [3:0] KIND_LBRC  = 4'd6;
  localparam logic [3:0] KIND_RBRC  = 4'd7;
  localparam logic [3:0] KIND_EQ    = 4'd8;
  localparam logic [3:0] KIND_COMMA = 4'd9;
  localparam logic [3:0] KIND_DOT   = 4'd10;
  localparam logic [3:0] KIND_PLUS  = 4'd11;
  localparam logic [3:0] KIND_EOF   = 4'd12;
  localparam logic [3:0] KIND_ERROR = 4'd13;

  // Character codes.
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_INT   = 3'd1,
    MODE_FLOAT = 3'd2,
    MODE_ID    = 3'd3,
    MODE_ERROR = 3'd4
  } scan_mode_t;

  // One result token.
  typedef struct packed {
    logic [3:0]       kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] length;
    logic [OUT_W-1:0] line;
    logic [7:0]       bad;
    logic             last;
  } token_t;

  // Results of one scanner step: up to two tokens, first one first.
  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } scan_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_CR);
  endfunction

  // Kind of a single-byte token; KIND_ERROR when the byte is none of them.
  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_SEMI:  k = KIND_SEMI;
      CH_LPAR:  k = KIND_LPAR;
      CH_RPAR:  k = KIND_RPAR;
      CH_LBRC:  k = KIND_LBRC;
      CH_RBRC:  k = KIND_RBRC;
      CH_EQ:    k = KIND_EQ;
      CH_COMMA: k = KIND_COMMA;
      CH_DOT:   k = KIND_DOT;
      CH_PLUS:  k = KIND_PLUS;
      default:  k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Clamp an internal position to the width of a token field.
  function automatic logic [OUT_W-1:0] sat_out(input logic [POS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(OUT_MAX)) return OUT_MAX;
    return w[OUT_W-1:0];
  endfunction

endpackage

>>> hdl/sst_scan.sv
// ----------------------------------------------------------------------------
// sst_scan
// Scanner state and per-byte classification; one step per accepted item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sst_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output sst_pkg::scan_res_t res
);

  sst_pkg::scan_mode_t        mode_r, mode_nxt;
  logic [sst_pkg::POS_W-1:0]  start_r, start_nxt;
  logic [sst_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [sst_pkg::POS_W-1:0]  line_r, line_nxt;

  logic                       pend_emit;
  logic                       cls_emit;
  logic                       run_cls;
  logic [3:0]                 pend_kind;
  logic [3:0]                 pkind;
  logic [sst_pkg::POS_W-1:0]  pend_len;
  sst_pkg::token_t            pend_tok;
  sst_pkg::token_t            cls_tok;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sst_pkg::MODE_IDLE;
      start_r <= '0;
      pos_r   <= '0;
      line_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
    end
  end

  // The pending token as it stands before this byte.
  always_comb begin
    unique case (mode_r)
      sst_pkg::MODE_INT:   pend_kind = sst_pkg::KIND_INT;
      sst_pkg::MODE_FLOAT: pend_kind = sst_pkg::KIND_FLOAT;
      default:             pend_kind = sst_pkg::KIND_ID;
    endcase
    pend_len        = (pos_r >= start_r) ? (pos_r - start_r) : '0;
    pend_tok.kind   = pend_kind;
    pend_tok.start  = sst_pkg::sat_out(start_r);
    pend_tok.length = sst_pkg::sat_out(pend_len);
    pend_tok.line   = sst_pkg::sat_out(line_r);
    pend_tok.bad    = 8'h00;
    pend_tok.last   = 1'b0;
  end

  // Next state and the token made by the byte itself.
  always_comb begin
    pkind           = sst_pkg::punct_kind(text_byte);
    mode_nxt        = mode_r;
    start_nxt       = start_r;
    pos_nxt         = (pos_r != '1) ? pos_r + 1'b1 : pos_r;
    line_nxt        = line_r;
    pend_emit       = 1'b0;
    cls_emit        = 1'b0;
    run_cls         = 1'b0;
    cls_tok.kind    = pkind;
    cls_tok.start   = sst_pkg::sat_out(pos_r);
    cls_tok.length  = sst_pkg::OUT_W'(1);
    cls_tok.line    = sst_pkg::sat_out(line_r);
    cls_tok.bad     = 8'h00;
    cls_tok.last    = 1'b1;

    if (end_of_text) begin
      // Finish any pending token, then EOF, then back to the reset state.
      pend_emit = (mode_r == sst_pkg::MODE_INT) || (mode_r == sst_pkg::MODE_FLOAT) ||
                  (mode_r == sst_pkg::MODE_ID);
      cls_emit       = 1'b1;
      cls_tok.kind   = sst_pkg::KIND_EOF;
      cls_tok.length = '0;
      mode_nxt       = sst_pkg::MODE_IDLE;
      start_nxt      = '0;
      pos_nxt        = '0;
      line_nxt       = '0;
    end else begin
      // Extend the pending token, or close it and classify the byte.
      unique case (mode_r)
        sst_pkg::MODE_INT: begin
          if (text_byte == sst_pkg::CH_DOT) begin
            mode_nxt = sst_pkg::MODE_FLOAT;
          end else if (!sst_pkg::is_digit(text_byte)) begin
            pend_emit = 1'b1;
            run_cls   = 1'b1;
          end
        end
        sst_pkg::MODE_FLOAT: begin
          if (!sst_pkg::is_digit(text_byte) && (text_byte != sst_pkg::CH_DOT)) begin
            pend_emit = 1'b1;
            run_cls   = 1'b1;
          end
        end
        sst_pkg::MODE_ID: begin
          if (!sst_pkg::is_alpha(text_byte) && !sst_pkg::is_digit(text_byte) &&
              (text_byte != sst_pkg::CH_UNDER)) begin
            pend_emit = 1'b1;
            run_cls   = 1'b1;
          end
        end
        sst_pkg::MODE_ERROR: begin
          run_cls = 1'b0;
        end
        default: begin
          run_cls = 1'b1;
        end
      endcase

      if (run_cls) begin
        mode_nxt = sst_pkg::MODE_IDLE;
        priority if (sst_pkg::is_blank(text_byte)) begin
          mode_nxt = sst_pkg::MODE_IDLE;
        end else if (text_byte == sst_pkg::CH_NL) begin
          line_nxt = (line_r != '1) ? line_r + 1'b1 : line_r;
        end else if (sst_pkg::is_digit(text_byte)) begin
          mode_nxt  = sst_pkg::MODE_INT;
          start_nxt = pos_r;
        end else if (sst_pkg::is_alpha(text_byte) || (text_byte == sst_pkg::CH_UNDER)) begin
          mode_nxt  = sst_pkg::MODE_ID;
          start_nxt = pos_r;
        end else if (pkind != sst_pkg::KIND_ERROR) begin
          cls_emit = 1'b1;
        end else begin
          cls_emit    = 1'b1;
          cls_tok.bad = text_byte;
          mode_nxt    = sst_pkg::MODE_ERROR;
        end
      end
    end
  end

  // Order the results: a closed pending token always goes first.
  always_comb begin
    res.v0      = pend_emit | cls_emit;
    res.v1      = pend_emit & cls_emit;
    res.t0      = pend_emit ? pend_tok : cls_tok;
    res.t0.last = !(pend_emit & cls_emit);
    res.t1      = cls_tok;
  end

  // A step on end of text always yields a final EOF token and clears state.
  `ASSERT_CLK(a_eot_gives_eof, step && end_of_text |-> res.v0 &&
    ((res.v1 && res.t1.kind == sst_pkg::KIND_EOF) ||
     (!res.v1 && res.t0.kind == sst_pkg::KIND_EOF)), "end of text without EOF token")
  `ASSERT_CLK(a_eot_clears, $past(step && end_of_text) |-> pos_r == '0 &&
    line_r == '0 && mode_r == sst_pkg::MODE_IDLE, "state not cleared after end of text")
  // After an error only end of text produces a result.
  `ASSERT_CLK(a_error_silent, step && !end_of_text && mode_r == sst_pkg::MODE_ERROR |->
    !res.v0 && mode_nxt == sst_pkg::MODE_ERROR, "result produced in error mode")
  // Two results never come without a pending token.
  `ASSERT_NEVER(a_two_need_pending, res.v1 && mode_r != sst_pkg::MODE_INT &&
    mode_r != sst_pkg::MODE_FLOAT && mode_r != sst_pkg::MODE_ID,
    "two results without a pending token")

endmodule

>>> hdl/sst_resq.sv
// ----------------------------------------------------------------------------
// sst_resq
// Small result queue: up to two tokens in a cycle, one out a cycle if ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sst_resq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sst_pkg::scan_res_t res,
  output logic               room2,
  output logic               out_valid,
  input  logic               out_ready,
  output sst_pkg::token_t    out_tok
);

  sst_pkg::token_t                  mem_r [sst_pkg::RESQ_DEPTH];
  logic [sst_pkg::RESQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sst_pkg::RESQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sst_pkg::RESQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sst_pkg::RESQ_PTR_W-1:0]   wr_ptr_p1;
  logic                             pop;
  logic                             wr0;
  logic                             wr1;

  // Pointer and count arithmetic.
  always_comb begin
    pop        = out_valid & out_ready;
    wr0        = push & res.v0;
    wr1        = push & res.v1;
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + sst_pkg::RESQ_PTR_W'(wr0) + sst_pkg::RESQ_PTR_W'(wr1);
    rd_ptr_nxt = rd_ptr_r + sst_pkg::RESQ_PTR_W'(pop);
    cnt_nxt    = cnt_r + sst_pkg::RESQ_CNT_W'(wr0) + sst_pkg::RESQ_CNT_W'(wr1) -
                 sst_pkg::RESQ_CNT_W'(pop);
  end

  assign room2     = cnt_r <= sst_pkg::RESQ_CNT_W'(sst_pkg::RESQ_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_tok   = mem_r[rd_ptr_r];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Token storage, written in order at one or two slots.
  always_ff @(posedge clk) begin
    if (wr0) begin
      mem_r[wr_ptr_r] <= res.t0;
    end
    if (wr1) begin
      mem_r[wr_ptr_p1] <= res.t1;
    end
  end

  // The queue never overflows and never pops while empty.
  `ASSERT_NEVER(a_no_overflow, cnt_r > sst_pkg::RESQ_CNT_W'(sst_pkg::RESQ_DEPTH),
    "result queue overflow")
  `ASSERT_CLK(a_push_has_room, push |-> room2, "push without room for two tokens")
  `ASSERT_CLK(a_count_tracks_ptrs, cnt_r != sst_pkg::RESQ_CNT_W'(sst_pkg::RESQ_DEPTH) |->
    sst_pkg::RESQ_PTR_W'(cnt_r) == (wr_ptr_r - rd_ptr_r), "count disagrees with pointers")

endmodule

>>> hdl/shader_source_tokenizer.sv
// ----------------------------------------------------------------------------
// shader_source_tokenizer
// Streaming lexer for shader source text: bytes in, tokens out.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata                              tuser / tlast
//  in_      slave      [7:0] text byte                    tuser: end_of_text
//  out_     master     start, length, line, bad byte      tuser: kind; tlast: last_of_run
//
//  An accepted item is held in an input register, scanned once two result slots are free;
//  its tokens enter a four-entry result queue that feeds the output port.
//  Throughput is one item per cycle if no item yields two tokens and the output is ready;
//  an item that yields two tokens uses two output beats, so the queue absorbs it.
//  An item's first token reaches the output through the input register and the queue.
//  Reset (rst_n low, synchronous) clears the scanner state and empties the queue.
//  A stalled output fills the queue; the input then stalls until two slots free.
// ----------------------------------------------------------------------------
module shader_source_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] token_start, [31:16] token_length,
                                  // [47:32] line_number, [55:48] bad_char
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_of_run
);

  logic               in_vld_r;
  logic [7:0]         in_byte_r;
  logic               in_eot_r;
  logic               step;
  logic               room2;
  sst_pkg::scan_res_t res;
  sst_pkg::token_t    out_tok;

  // The held item is scanned once the queue can take both possible tokens.
  assign step      = in_vld_r & room2;
  assign in_tready = !in_vld_r | step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tuser;
    end
  end

  sst_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .text_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .res         (res)
  );

  sst_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .res       (res),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok)
  );

  // Pack the token onto the output port.
  assign out_tdata = {out_tok.bad, out_tok.line, out_tok.length, out_tok.start};
  assign out_tuser = out_tok.kind;
  assign out_tlast = out_tok.last;

endmodule
